// ===== rtl/pcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants for the price channel breakout block: bar and
// result payloads, breakout codes and the scan control bundle.
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int PRICE_BITS = 32;
    localparam int WINDOW_BITS = 9;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 9'd20;

    typedef logic [PRICE_BITS-1:0] pcb_price_t;

    typedef enum logic [1:0] {
        ALERT_NEUTRAL = 2'd0,
        ALERT_LONG    = 2'd1,
        ALERT_SHORT   = 2'd2
    } pcb_alert_t;

    typedef struct packed {
        pcb_price_t bar_high;
        pcb_price_t bar_low;
        pcb_price_t bar_close;
    } pcb_bar_t;

    typedef struct packed {
        pcb_price_t upper_band;
        pcb_price_t lower_band;
        logic       band_valid;
        pcb_alert_t alert_status;
    } pcb_result_t;

    typedef struct packed {
        logic acc_en;
        logic first;
    } pcb_acc_ctrl_t;

endpackage

// ===== rtl/pcb_history.sv =====
// ----------------------------------------------------------------------------
// pcb_history
// Ring memory of past bar highs and lows: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pcb_history #(
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pcb_pkg::pcb_price_t wr_high,
    input  pcb_pkg::pcb_price_t wr_low,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pcb_pkg::pcb_price_t rd_high,
    output pcb_pkg::pcb_price_t rd_low
);

    pcb_pkg::pcb_price_t high_mem [DEPTH];
    pcb_pkg::pcb_price_t low_mem [DEPTH];
    pcb_pkg::pcb_price_t rd_high_reg;
    pcb_pkg::pcb_price_t rd_low_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            high_mem[wr_addr] <= wr_high;
            low_mem[wr_addr]  <= wr_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_high_reg <= high_mem[rd_addr];
            rd_low_reg  <= low_mem[rd_addr];
        end
    end

    assign rd_high = rd_high_reg;
    assign rd_low  = rd_low_reg;

endmodule

// ===== rtl/pcb_extreme.sv =====
// ----------------------------------------------------------------------------
// pcb_extreme
// Compare unit: folds one stored high and low per cycle, while ctrl.acc_en is
// set, into the running highest high and lowest low.
// ----------------------------------------------------------------------------
module pcb_extreme (
    input  logic                   clk,
    input  pcb_pkg::pcb_acc_ctrl_t ctrl,
    input  pcb_pkg::pcb_price_t    sample_high,
    input  pcb_pkg::pcb_price_t    sample_low,
    output pcb_pkg::pcb_price_t    upper,
    output pcb_pkg::pcb_price_t    lower
);

    pcb_pkg::pcb_price_t upper_reg;
    pcb_pkg::pcb_price_t lower_reg;
    pcb_pkg::pcb_price_t upper_next;
    pcb_pkg::pcb_price_t lower_next;

    always_comb
    begin
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (ctrl.first || (sample_high > upper_reg))
        begin
            upper_next = sample_high;
        end
        if (ctrl.first || (sample_low < lower_reg))
        begin
            lower_next = sample_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

    assign upper = upper_reg;
    assign lower = lower_reg;

endmodule

// ===== rtl/price_channel_breakout.sv =====
// ----------------------------------------------------------------------------
// price_channel_breakout
// Channel breakout on price bars: highest high and lowest low of the previous
// window bars, and a long/short breakout state driven by the close.
//
//   channel  signals                        direction  handshake
//   in       in_valid, in_ready, in_data    sink       valid/ready
//   out      out_valid, out_ready, out_data source     valid/ready
//   cfg      cfg_we, cfg_wdata              sink       write enable only
//
// A bar with a full window makes one history read per window bar through the
// single memory read port, then passes ST_DRAIN while the last read lands and
// ST_FINISH, which decides and stores the bar. A bar before the window is full
// goes from ST_IDLE straight to ST_FINISH.
// Reset clears the ring pointer, bar count, breakout state and output valid;
// window_reg returns to 20. A full output register stalls the decide step.
// ----------------------------------------------------------------------------
module price_channel_breakout #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [8:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcb_pkg::pcb_bar_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcb_pkg::pcb_result_t  out_data
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int WIDE_W = (CNT_W > pcb_pkg::WINDOW_BITS) ? CNT_W : pcb_pkg::WINDOW_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [pcb_pkg::WINDOW_BITS-1:0] window_reg;
    logic [SLOT_W-1:0]               write_slot_reg;
    logic [CNT_W-1:0]                bars_seen_reg;
    pcb_pkg::pcb_alert_t             alert_reg;
    pcb_pkg::pcb_bar_t               bar_reg;
    logic                            band_valid_reg;
    logic [SLOT_W-1:0]               rd_addr_reg;
    logic [CNT_W-1:0]                scan_cnt_reg;
    logic                            issue_first_reg;
    pcb_pkg::pcb_acc_ctrl_t          acc_ctrl_reg;
    logic                            out_valid_reg;
    pcb_pkg::pcb_result_t            out_data_reg;

    logic [WIDE_W-1:0]               window_wide;
    logic [CNT_W-1:0]                eff_window;
    logic [SLOT_W-1:0]               start_addr;
    logic [SLOT_W-1:0]               rd_addr_next;
    logic [SLOT_W-1:0]               write_slot_next;
    logic                            out_free;
    logic                            finish_go;
    pcb_pkg::pcb_alert_t             alert_next;
    pcb_pkg::pcb_price_t             rd_high;
    pcb_pkg::pcb_price_t             rd_low;
    pcb_pkg::pcb_price_t             upper;
    pcb_pkg::pcb_price_t             lower;

    always_comb
    begin
        window_wide = WIDE_W'(window_reg);
        if (window_reg == '0)
        begin
            eff_window = CNT_W'(1);
        end
        else if (window_wide > WIDE_W'(MAX_WINDOW))
        begin
            eff_window = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_window = CNT_W'(window_wide);
        end
    end

    assign start_addr = (write_slot_reg == '0) ? SLOT_W'(MAX_WINDOW - 1)
                                               : write_slot_reg - SLOT_W'(1);
    assign rd_addr_next = (rd_addr_reg == '0) ? SLOT_W'(MAX_WINDOW - 1)
                                              : rd_addr_reg - SLOT_W'(1);
    assign write_slot_next = (write_slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                         : write_slot_reg + SLOT_W'(1);

    assign out_free  = !out_valid_reg || out_ready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        alert_next = alert_reg;
        if (!band_valid_reg)
        begin
            alert_next = pcb_pkg::ALERT_NEUTRAL;
        end
        else
        begin
            unique case (alert_reg)
                pcb_pkg::ALERT_SHORT:
                begin
                    if (bar_reg.bar_close > upper)
                    begin
                        alert_next = pcb_pkg::ALERT_LONG;
                    end
                end
                pcb_pkg::ALERT_LONG:
                begin
                    if (bar_reg.bar_close < lower)
                    begin
                        alert_next = pcb_pkg::ALERT_SHORT;
                    end
                end
                default:
                begin
                    if (bar_reg.bar_close > upper)
                    begin
                        alert_next = pcb_pkg::ALERT_LONG;
                    end
                    else if (bar_reg.bar_close < lower)
                    begin
                        alert_next = pcb_pkg::ALERT_SHORT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pcb_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            bars_seen_reg   <= '0;
            alert_reg       <= pcb_pkg::ALERT_NEUTRAL;
            acc_ctrl_reg    <= '0;
            out_valid_reg   <= 1'b0;
            issue_first_reg <= 1'b0;
            bar_reg         <= '0;
            band_valid_reg  <= 1'b0;
            rd_addr_reg     <= '0;
            scan_cnt_reg    <= '0;
            out_data_reg    <= '0;
        end
        else
        begin
            acc_ctrl_reg.acc_en <= (state_reg == ST_SCAN);
            acc_ctrl_reg.first  <= (state_reg == ST_SCAN) && issue_first_reg;
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        bar_reg         <= in_data;
                        band_valid_reg  <= (bars_seen_reg >= eff_window);
                        rd_addr_reg     <= start_addr;
                        scan_cnt_reg    <= eff_window;
                        issue_first_reg <= 1'b1;
                        state_reg       <= (bars_seen_reg >= eff_window) ? ST_SCAN
                                                                         : ST_FINISH;
                    end
                end
                ST_SCAN:
                begin
                    issue_first_reg     <= 1'b0;
                    rd_addr_reg         <= rd_addr_next;
                    scan_cnt_reg        <= scan_cnt_reg - CNT_W'(1);
                    if (scan_cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_data_reg.upper_band      <= band_valid_reg ? upper : '0;
                        out_data_reg.lower_band      <= band_valid_reg ? lower : '0;
                        out_data_reg.band_valid      <= band_valid_reg;
                        out_data_reg.alert_status    <= alert_next;
                        alert_reg                    <= alert_next;
                        write_slot_reg               <= write_slot_next;
                        if (bars_seen_reg != CNT_W'(MAX_WINDOW))
                        begin
                            bars_seen_reg <= bars_seen_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    pcb_history #(
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk     (clk),
        .wr_en   (finish_go),
        .wr_addr (write_slot_reg),
        .wr_high (bar_reg.bar_high),
        .wr_low  (bar_reg.bar_low),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (rd_addr_reg),
        .rd_high (rd_high),
        .rd_low  (rd_low)
    );

    pcb_extreme u_extreme (
        .clk         (clk),
        .ctrl        (acc_ctrl_reg),
        .sample_high (rd_high),
        .sample_low  (rd_low),
        .upper       (upper),
        .lower       (lower)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
